>>> design/lsd_pkg.sv
`default_nettype none

package lsd_pkg;

  // Default geometry of the stack and of the id space.
  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned DOC_ID_BITS = 16;

  // Fixed widths of the payload ports.
  localparam int unsigned DOC_ID_W   = 16;
  localparam int unsigned DISTANCE_W = 9;

  typedef enum logic [1:0] {
    LSD_CLEAR,
    LSD_IDLE,
    LSD_LOOK
  } lsd_state_e;

endpackage

`default_nettype wire

>>> design/lsd_ram.sv
`default_nettype none

module lsd_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic                     we_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

>>> design/lsd_cell.sv
`default_nettype none

module lsd_cell #(
  parameter int unsigned IdBits = lsd_pkg::DOC_ID_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              capture_i,
  input  wire logic [IdBits-1:0] id_i,
  input  wire logic              valid_i,
  input  wire logic              shift_i,
  input  wire logic [IdBits-1:0] prev_i,
  output logic      [IdBits-1:0] entry_o,
  output logic                   match_o
);

  logic [IdBits-1:0] entry_q;
  logic              match_q;

  // Take the neighbor's entry on a shift; latch the compare on capture.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= prev_i;
    end
    if (capture_i) begin
      match_q <= valid_i && (entry_q == id_i);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

>>> design/lsd_hit_scan.sv
`default_nettype none

module lsd_hit_scan #(
  parameter int unsigned StackDepth = lsd_pkg::STACK_DEPTH
) (
  input  wire logic [StackDepth-1:0]         match_i,
  output logic                               hit_o,
  output logic      [$clog2(StackDepth)-1:0] pos_o,
  output logic      [StackDepth-1:0]         before_o
);

  localparam int unsigned Levels = $clog2(StackDepth);
  localparam int unsigned PosW   = $clog2(StackDepth);

  logic [StackDepth-1:0] lvl [Levels+1];

  // Parallel prefix OR: lvl[Levels][k] is set when any cell 0..k matched.
  always_comb begin
    lvl[0] = match_i;
    for (int l = 0; l < Levels; l++) begin
      for (int k = 0; k < StackDepth; k++) begin
        if (k >= (1 << l)) begin
          lvl[l+1][k] = lvl[l][k] | lvl[l][k - (1 << l)];
        end else begin
          lvl[l+1][k] = lvl[l][k];
        end
      end
    end
  end

  always_comb begin
    before_o[0] = 1'b0;
    for (int k = 1; k < StackDepth; k++) begin
      before_o[k] = lvl[Levels][k-1];
    end
  end

  assign hit_o = lvl[Levels][StackDepth-1];

  // Ids in the stack are distinct, so at most one match: encode by OR.
  always_comb begin
    pos_o = '0;
    for (int k = 0; k < StackDepth; k++) begin
      if (match_i[k]) begin
        pos_o = pos_o | PosW'(k);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/lru_stack_distance_core.sv
// Result path: an accepted transaction goes to the look-up state, then to the
//   output register; the commit waits while a stalled receiver holds it.
// Input: a new transaction waits until the previous one commits, set by the
//   compare-then-shift pass through the cell row and the read-then-write of
//   the seen-id RAM.
// Reset: rst_ni clears control state at once, then a clearing pass over all
//   2**DocIdBits entries (65536 by default) zeroes the seen-id RAM; no input
//   is accepted until it is done.
`default_nettype none

module lru_stack_distance_core #(
  parameter int unsigned StackDepth = lsd_pkg::STACK_DEPTH,
  parameter int unsigned DocIdBits  = lsd_pkg::DOC_ID_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [lsd_pkg::DOC_ID_W-1:0]    doc_id_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [lsd_pkg::DISTANCE_W-1:0]  distance_o,
  output logic                                 first_reference_o,
  output logic                                 beyond_depth_o
);

  localparam int unsigned FillW  = $clog2(StackDepth + 1);
  localparam int unsigned PosW   = $clog2(StackDepth);
  localparam int unsigned IdSpace = 1 << DocIdBits;

  lsd_pkg::lsd_state_e state_q, state_d;

  logic [DocIdBits-1:0] clr_q, clr_d;
  logic [DocIdBits-1:0] id_q;
  logic [DocIdBits-1:0] id_in;
  logic [FillW-1:0]     fill_q, fill_d;

  logic                 out_valid_q, out_valid_d;
  logic [lsd_pkg::DISTANCE_W-1:0] distance_q;
  logic                 first_q;
  logic                 beyond_q;

  logic                 accept;
  logic                 commit;
  logic                 ram_we;
  logic [DocIdBits-1:0] ram_addr;
  logic                 ram_wdata;
  logic                 seen;

  logic [DocIdBits-1:0]  entry [StackDepth];
  logic [StackDepth-1:0] match;
  logic [StackDepth-1:0] hit_above;
  logic                  hit;
  logic [PosW-1:0]       pos;
  logic [PosW:0]         dist_wide;

  // Keep only the low DocIdBits of the incoming id.
  assign id_in  = DocIdBits'(doc_id_i);
  assign accept = in_valid_i && in_ready_o;

  // ------------------------------------------------------------------
  // Sequencer: clearing pass, then accept / look-up-and-commit.
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      lsd_pkg::LSD_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == DocIdBits'(IdSpace - 1)) begin
          state_d = lsd_pkg::LSD_IDLE;
        end
      end
      lsd_pkg::LSD_IDLE: begin
        if (in_valid_i) begin
          state_d = lsd_pkg::LSD_LOOK;
        end
      end
      lsd_pkg::LSD_LOOK: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = lsd_pkg::LSD_IDLE;
        end
      end
      default: state_d = lsd_pkg::LSD_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = 1'b1;
    ram_addr   = id_q;
    unique case (state_q)
      lsd_pkg::LSD_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b0;
        ram_addr  = clr_q;
      end
      lsd_pkg::LSD_IDLE: begin
        // Read the seen bit alongside the cell compare.
        in_ready_o = 1'b1;
        ram_addr   = id_in;
      end
      lsd_pkg::LSD_LOOK: begin
        // Commit once the output register is free; mark the id as seen.
        commit = !out_valid_q || out_ready_i;
        ram_we = commit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsd_pkg::LSD_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q <= id_in;
    end
  end

  lsd_ram #(
    .Width (1),
    .Depth (IdSpace)
  ) u_seen_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (seen)
  );

  // ------------------------------------------------------------------
  // Cell row: index 0 is the most recent id. Each cell latches its
  // compare at accept; on commit the cells from the top down to the hit
  // (or to the fill point on a miss) take their upper neighbor's entry,
  // and cell 0 takes the referenced id.
  // ------------------------------------------------------------------
  for (genvar k = 0; k < StackDepth; k++) begin : g_cell
    logic [DocIdBits-1:0] prev;
    logic                 shift;

    if (k == 0) begin : g_top
      assign prev = id_q;
    end else begin : g_below
      assign prev = entry[k-1];
    end

    assign shift = commit && (hit ? !hit_above[k] : (FillW'(k) <= fill_q));

    lsd_cell #(
      .IdBits (DocIdBits)
    ) u_cell (
      .clk_i     (clk_i),
      .capture_i (accept),
      .id_i      (id_in),
      .valid_i   (FillW'(k) < fill_q),
      .shift_i   (shift),
      .prev_i    (prev),
      .entry_o   (entry[k]),
      .match_o   (match[k])
    );
  end

  lsd_hit_scan #(
    .StackDepth (StackDepth)
  ) u_hit_scan (
    .match_i  (match),
    .hit_o    (hit),
    .pos_o    (pos),
    .before_o (hit_above)
  );

  assign dist_wide = {1'b0, pos} + 1'b1;

  // Grow the fill count on a miss until the row is full; a full row
  // drops its least recent entry instead.
  always_comb begin
    fill_d = fill_q;
    if (commit && !hit && (fill_q != FillW'(StackDepth))) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // ------------------------------------------------------------------
  // Output register: holds a result while the next transaction comes in.
  // ------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      distance_q <= hit ? lsd_pkg::DISTANCE_W'(dist_wide) : '0;
      first_q    <= !hit && !seen;
      beyond_q   <= !hit && seen;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign distance_o        = distance_q;
  assign first_reference_o = first_q;
  assign beyond_depth_o    = beyond_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(StackDepth))
    else $error("fill count exceeds stack depth");

  a_hit_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsd_pkg::LSD_LOOK) && hit |-> fill_q != '0)
    else $error("hit reported on an empty stack");

  a_result_from_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == lsd_pkg::LSD_LOOK))
    else $error("result raised outside a look-up");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({distance_o != '0, first_reference_o, beyond_depth_o}))
    else $error("result is not exactly one of hit, first or beyond depth");

endmodule

`default_nettype wire

>>> tb/lru_stack_distance_core_tb.sv
`default_nettype none

module lru_stack_distance_core_tb;

  // Geometry of the block under test, taken from the package defaults.
  localparam int unsigned DEPTH        = lsd_pkg::STACK_DEPTH;
  localparam int unsigned ID_BITS      = lsd_pkg::DOC_ID_BITS;
  localparam int unsigned ID_W         = lsd_pkg::DOC_ID_W;
  localparam int unsigned DIST_W       = lsd_pkg::DISTANCE_W;

  // Stimulus shape and run bounds.
  localparam int unsigned TOTAL_REFS   = 1650;
  localparam int unsigned RECENT_DEPTH = DEPTH + 64;  // deeper than the stack to reach drop-offs
  localparam int unsigned HOLD_AFTER   = 500;         // accepted refs before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_AT     = 800;         // random ref that waits for a full drain
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  // Expected outcome of one reference.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              first_ref;
    logic              beyond;
  } lru_verdict_t;

  // One queued reference; drain_first holds it back until every result is in.
  typedef struct packed {
    logic [ID_W-1:0] doc_id;
    logic            drain_first;
  } ref_item_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_HALF,
    RX_SPARSE,
    RX_EVERY_THIRD
  } rx_mode_e;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic [ID_W-1:0] doc_id    = '0;
  logic            out_ready = 1'b0;

  logic              in_ready_o;
  logic              out_valid_o;
  logic [DIST_W-1:0] distance_o;
  logic              first_reference_o;
  logic              beyond_depth_o;

  lru_stack_distance_core dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .doc_id_i          (doc_id),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .distance_o        (distance_o),
    .first_reference_o (first_reference_o),
    .beyond_depth_o    (beyond_depth_o)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow LRU stack: ids most recent first, fill count and seen-id map.
  // ---------------------------------------------------------------------------
  logic [ID_BITS-1:0] lru_ids [DEPTH];
  int unsigned        lru_fill = 0;
  bit                 seen_ids [1 << ID_BITS];

  // Rank one reference against the shadow stack, then move the id to the top.
  function automatic lru_verdict_t rank_reference(input logic [ID_W-1:0] raw_id);
    logic [ID_BITS-1:0] id;
    int unsigned        pos;
    int unsigned        last;
    bit                 hit;
    lru_verdict_t       v;
    id  = raw_id[ID_BITS-1:0];
    hit = 1'b0;
    pos = 0;
    v   = '0;
    for (int unsigned k = 0; k < lru_fill; k++) begin
      if (!hit && lru_ids[k] == id) begin
        hit = 1'b1;
        pos = k;
      end
    end
    if (hit) begin
      v.distance = DIST_W'(pos + 1);
      last = pos;
    end else begin
      if (seen_ids[id]) v.beyond = 1'b1;
      else v.first_ref = 1'b1;
      seen_ids[id] = 1'b1;
      if (lru_fill < DEPTH) begin
        last = lru_fill;
        lru_fill++;
      end else begin
        last = DEPTH - 1;  // bottom entry drops off, its seen bit stays set
      end
    end
    for (int k = last; k > 0; k--) lru_ids[k] = lru_ids[k - 1];
    lru_ids[0] = id;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus bookkeeping.
  // ---------------------------------------------------------------------------
  ref_item_t       ref_pending[$];
  lru_verdict_t    pending_verdicts[$];
  logic [ID_W-1:0] recent_ids[$];  // generator-side recency list, most recent first

  int unsigned cycle_count   = 0;
  int unsigned refs_accepted = 0;
  int unsigned errors        = 0;
  int unsigned n_first       = 0;
  int unsigned n_hits        = 0;
  int unsigned n_beyond      = 0;
  int unsigned n_drains      = 0;
  int unsigned deepest_hit   = 0;
  logic        in_fire_seen  = 1'b0;

  // Queue a reference and keep the recency list in step so that later picks
  // can aim at a chosen stack position.
  task automatic offer_ref(input logic [ID_W-1:0] id, input logic drain);
    ref_item_t item;
    int        idx;
    item.doc_id      = id;
    item.drain_first = drain;
    ref_pending.push_back(item);
    if (drain) n_drains++;
    idx = -1;
    for (int k = 0; k < recent_ids.size(); k++) begin
      if (idx < 0 && recent_ids[k] == id) idx = k;
    end
    if (idx >= 0) recent_ids.delete(idx);
    recent_ids.push_front(id);
    if (recent_ids.size() > RECENT_DEPTH) void'(recent_ids.pop_back());
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present one reference per transaction, in bursts with gaps.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin
    ref_item_t head;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire_seen) begin
      // Hold valid and payload until the transaction is taken.
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (ref_pending.size() != 0 &&
                 !(ref_pending[0].drain_first && pending_verdicts.size() != 0)) begin
      head = ref_pending.pop_front();
      in_valid <= 1'b1;
      doc_id   <= head.doc_id;
      if (burst_left <= 1) begin
        // Start a new burst; half the time with no gap in front of it.
        burst_left = $urandom_range(1, 16);
        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end else begin
      // Idle: nothing queued, or waiting for the block to drain.
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a rotating pattern, plus one long hold-off that lets
  // the block back up and stall its input.
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode      = RX_FREE;
  int unsigned rx_phase     = 0;
  int unsigned rx_hold_left = 0;
  bit          rx_hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (!rx_hold_done && refs_accepted >= HOLD_AFTER) begin
      rx_hold_done = 1'b1;
      rx_hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      // Advance to a new pattern every so often.
      rx_phase++;
      if (rx_phase % 150 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_FREE:        out_ready <= 1'b1;
        RX_HALF:        out_ready <= ($urandom_range(0, 1) == 0);
        RX_SPARSE:      out_ready <= ($urandom_range(0, 3) == 0);
        RX_EVERY_THIRD: out_ready <= (rx_phase % 3 != 0);
        default:        out_ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: rank each accepted reference, check each accepted result
  // against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lru_verdict_t want;
    cycle_count++;
    if (rst_n) begin
      in_fire_seen <= in_valid && in_ready_o;
      if (in_valid && in_ready_o) begin
        want = rank_reference(doc_id);
        pending_verdicts.push_back(want);
        refs_accepted++;
        if (want.first_ref) n_first++;
        else if (want.beyond) n_beyond++;
        else begin
          n_hits++;
          if (32'(want.distance) > deepest_hit) deepest_hit = 32'(want.distance);
        end
      end
      if (out_valid_o && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result with no reference outstanding: distance %0d first %0b beyond %0b",
                 distance_o, first_reference_o, beyond_depth_o);
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (distance_o !== want.distance) begin
            $error("distance mismatch: expected %0d, actual %0d", want.distance, distance_o);
            errors++;
          end
          if (first_reference_o !== want.first_ref) begin
            $error("first_reference mismatch: expected %0b, actual %0b",
                   want.first_ref, first_reference_o);
            errors++;
          end
          if (beyond_depth_o !== want.beyond) begin
            $error("beyond_depth mismatch: expected %0b, actual %0b",
                   want.beyond, beyond_depth_o);
            errors++;
          end
        end
      end
    end
  end

  // Drop the run if it stalls; the limit covers the clearing pass many times.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the reference stream, reset, wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n_random;
    int unsigned pick;
    int unsigned pos;
    int unsigned lo;
    logic [ID_W-1:0] id;

    // Directed refs: id extremes, hit at the top, short hits, alternating bits.
    offer_ref(16'h0000, 1'b0);  // first reference, lowest id
    offer_ref(16'hFFFF, 1'b0);  // first reference, highest id
    offer_ref(16'hFFFF, 1'b0);  // hit at the top, stack unchanged
    offer_ref(16'h0000, 1'b0);  // distance two
    offer_ref(16'hAAAA, 1'b0);
    offer_ref(16'h5555, 1'b0);
    offer_ref(16'h0001, 1'b0);
    offer_ref(16'h8000, 1'b0);
    offer_ref(16'hAAAA, 1'b0);  // distance four
    offer_ref(16'h8000, 1'b0);
    offer_ref(16'h8000, 1'b0);  // top again
    offer_ref(16'h0000, 1'b0);  // distance five
    offer_ref(16'h7FFF, 1'b0);
    offer_ref(16'hFFFE, 1'b0);
    offer_ref(16'h5555, 1'b0);

    // Random refs aimed at chosen stack positions: top, shallow, anywhere,
    // the bottom of a full stack, just past it, plus fresh ids as noise.
    n_random = TOTAL_REFS - ref_pending.size();
    for (int unsigned r = 0; r < n_random; r++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15 || recent_ids.size() == 0) begin
        id = ID_W'($urandom_range(0, 16'hFFFF));
      end else begin
        if (pick < 25) begin
          pos = 0;
        end else if (pick < 48) begin
          pos = $urandom_range(0, (recent_ids.size() < 8) ? recent_ids.size() - 1 : 7);
        end else if (pick < 76) begin
          pos = $urandom_range(0, recent_ids.size() - 1);
        end else if (recent_ids.size() > DEPTH) begin
          // Bottom of the stack and just beyond it.
          if (pick < 84) pos = DEPTH - 1;
          else if (pick < 90) pos = DEPTH;
          else begin
            lo  = DEPTH - 16;
            pos = $urandom_range(lo, recent_ids.size() - 1);
          end
        end else begin
          pos = recent_ids.size() - 1;
        end
        id = recent_ids[pos];
      end
      offer_ref(id, (r == 0 || r == DRAIN_AT));
    end

    // Release reset at a falling edge, after the driver has seen it low.
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (ref_pending.size() != 0 || in_valid) @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_verdicts.size() != 0) begin
      $error("%0d results never arrived", pending_verdicts.size());
      errors++;
    end

    $display("covered %0d references: %0d first, %0d hits (deepest %0d), %0d beyond depth",
             refs_accepted, n_first, n_hits, deepest_hit, n_beyond);
    $display("one %0d-cycle receiver hold-off, %0d full drains before a reference",
             HOLD_CYCLES, n_drains);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
